// ===== hdl/sbst_pkg.sv =====
package sbst_pkg;

    // Width of every coordinate field on the ports
    localparam int FIELD_W = 32;

    // Per-item decision flags carried down the pipeline beside the slab terms
    typedef struct packed {
        logic start_in; // start point lies in the closed box
        logic dx_zero;  // no motion along x
        logic dy_zero;  // no motion along y
        logic miss;     // already known to miss
    } sbst_flags_t;

endpackage

// ===== hdl/sbst_prep.sv =====
module sbst_prep #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  box_min_x,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  box_min_y,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  box_max_x,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  box_max_y,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  start_x,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  start_y,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  end_x,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  end_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [COORD_WIDTH:0]          enter_x,
    output logic signed [COORD_WIDTH:0]          leave_x,
    output logic signed [COORD_WIDTH:0]          enter_y,
    output logic signed [COORD_WIDTH:0]          leave_y,
    output logic        [COORD_WIDTH-1:0]        dmag_x,
    output logic        [COORD_WIDTH-1:0]        dmag_y,
    output sbst_pkg::sbst_flags_t                flags
);
    import sbst_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int D1 = COORD_WIDTH + 1;

    logic signed [CW-1:0] mnx, mny, mxx, mxy, sx, sy, ex, ey;

    // Stage 1: differences and the start-inside test
    logic              v1_reg;
    logic              inside_reg, inside_next;
    logic signed [CW:0] dx_reg, ax_reg, bx_reg, dy_reg, ay_reg, by_reg;
    logic signed [CW:0] dx_next, ax_next, bx_next, dy_next, ay_next, by_next;

    // Stage 2: oriented and sorted slab numerators
    logic              v2_reg;
    logic signed [CW:0] enter_x_reg, leave_x_reg, enter_y_reg, leave_y_reg;
    logic signed [CW:0] enter_x_next, leave_x_next, enter_y_next, leave_y_next;
    logic [CW-1:0]      dmag_x_reg, dmag_y_reg, dmag_x_next, dmag_y_next;
    sbst_flags_t        flags_reg, flags_next;

    logic               adv1, adv2;
    logic signed [CW:0] an_x, bn_x, an_y, bn_y, dabs_x, dabs_y;
    logic               slab_x, slab_y, zx, zy;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Take the low coordinate bits, sign-extended
    assign mnx = CW'(box_min_x);
    assign mny = CW'(box_min_y);
    assign mxx = CW'(box_max_x);
    assign mxy = CW'(box_max_y);
    assign sx  = CW'(start_x);
    assign sy  = CW'(start_y);
    assign ex  = CW'(end_x);
    assign ey  = CW'(end_y);

    always_comb begin
        inside_next = (sx >= mnx) && (sx <= mxx) && (sy >= mny) && (sy <= mxy);
        dx_next     = D1'(ex)  - D1'(sx);
        ax_next     = D1'(mnx) - D1'(sx);
        bx_next     = D1'(mxx) - D1'(sx);
        dy_next     = D1'(ey)  - D1'(sy);
        ay_next     = D1'(mny) - D1'(sy);
        by_next     = D1'(mxy) - D1'(sy);
    end

    always_comb begin
        // Flip the axis when moving backwards so the denominator is positive
        an_x   = dx_reg[CW] ? -ax_reg : ax_reg;
        bn_x   = dx_reg[CW] ? -bx_reg : bx_reg;
        dabs_x = dx_reg[CW] ? -dx_reg : dx_reg;
        an_y   = dy_reg[CW] ? -ay_reg : ay_reg;
        bn_y   = dy_reg[CW] ? -by_reg : by_reg;
        dabs_y = dy_reg[CW] ? -dy_reg : dy_reg;

        enter_x_next = (an_x < bn_x) ? an_x : bn_x;
        leave_x_next = (an_x < bn_x) ? bn_x : an_x;
        enter_y_next = (an_y < bn_y) ? an_y : bn_y;
        leave_y_next = (an_y < bn_y) ? bn_y : an_y;
        dmag_x_next  = dabs_x[CW-1:0];
        dmag_y_next  = dabs_y[CW-1:0];

        // Stationary axis: start must sit between the min and max edges
        zx     = (dx_reg == '0);
        zy     = (dy_reg == '0);
        slab_x = (ax_reg[CW] || (ax_reg == '0)) && !bx_reg[CW];
        slab_y = (ay_reg[CW] || (ay_reg == '0)) && !by_reg[CW];

        flags_next.start_in = inside_reg;
        flags_next.dx_zero  = zx;
        flags_next.dy_zero  = zy;
        flags_next.miss     = (zx && !slab_x) || (zy && !slab_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            inside_reg <= inside_next;
            dx_reg     <= dx_next;
            ax_reg     <= ax_next;
            bx_reg     <= bx_next;
            dy_reg     <= dy_next;
            ay_reg     <= ay_next;
            by_reg     <= by_next;
        end
        if (adv2) begin
            enter_x_reg <= enter_x_next;
            leave_x_reg <= leave_x_next;
            enter_y_reg <= enter_y_next;
            leave_y_reg <= leave_y_next;
            dmag_x_reg  <= dmag_x_next;
            dmag_y_reg  <= dmag_y_next;
            flags_reg   <= flags_next;
        end
    end

    assign out_valid = v2_reg;
    assign enter_x   = enter_x_reg;
    assign leave_x   = leave_x_reg;
    assign enter_y   = enter_y_reg;
    assign leave_y   = leave_y_reg;
    assign dmag_x    = dmag_x_reg;
    assign dmag_y    = dmag_y_reg;
    assign flags     = flags_reg;

endmodule

// ===== hdl/sbst_mul.sv =====
module sbst_mul #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [COORD_WIDTH:0]      enter_x,
    input  logic signed [COORD_WIDTH:0]      leave_x,
    input  logic signed [COORD_WIDTH:0]      enter_y,
    input  logic signed [COORD_WIDTH:0]      leave_y,
    input  logic        [COORD_WIDTH-1:0]    dmag_x,
    input  logic        [COORD_WIDTH-1:0]    dmag_y,
    input  sbst_pkg::sbst_flags_t            in_flags,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [2*COORD_WIDTH:0]    ex_dy,
    output logic signed [2*COORD_WIDTH:0]    ly_dx,
    output logic signed [2*COORD_WIDTH:0]    ey_dx,
    output logic signed [2*COORD_WIDTH:0]    lx_dy,
    output sbst_pkg::sbst_flags_t            out_flags
);
    import sbst_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int LW  = COORD_WIDTH / 2;
    localparam int HW  = COORD_WIDTH - LW;
    localparam int PLW = COORD_WIDTH + LW + 2;
    localparam int PHW = COORD_WIDTH + HW + 2;
    localparam int PW  = 2 * COORD_WIDTH + 1;

    logic signed [LW:0] dx_lo, dy_lo;
    logic signed [HW:0] dx_hi, dy_hi;

    // Stage 3: half-width partial products
    logic                 v3_reg, adv3;
    logic signed [PLW-1:0] exdy_lo_reg, lydx_lo_reg, eydx_lo_reg, lxdy_lo_reg;
    logic signed [PHW-1:0] exdy_hi_reg, lydx_hi_reg, eydx_hi_reg, lxdy_hi_reg;
    sbst_flags_t          flags3_reg, flags3_next;

    // Stage 4: full cross products
    logic                 v4_reg, adv4;
    logic signed [PW-1:0] ex_dy_reg, ly_dx_reg, ey_dx_reg, lx_dy_reg;
    logic signed [PW-1:0] ex_dy_next, ly_dx_next, ey_dx_next, lx_dy_next;
    sbst_flags_t          flags4_reg;

    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign in_ready = adv3;

    assign dx_lo = $signed({1'b0, dmag_x[LW-1:0]});
    assign dy_lo = $signed({1'b0, dmag_y[LW-1:0]});
    assign dx_hi = $signed({1'b0, dmag_x[CW-1:LW]});
    assign dy_hi = $signed({1'b0, dmag_y[CW-1:LW]});

    // Cheap bounds against t = 0 and t = 1 on each moving axis
    always_comb begin
        flags3_next      = in_flags;
        flags3_next.miss = in_flags.miss
            || (!in_flags.dx_zero && (leave_x[CW] || (enter_x > $signed({1'b0, dmag_x}))))
            || (!in_flags.dy_zero && (leave_y[CW] || (enter_y > $signed({1'b0, dmag_y}))));
    end

    always_comb begin
        ex_dy_next = (PW'(exdy_hi_reg) <<< LW) + PW'(exdy_lo_reg);
        ly_dx_next = (PW'(lydx_hi_reg) <<< LW) + PW'(lydx_lo_reg);
        ey_dx_next = (PW'(eydx_hi_reg) <<< LW) + PW'(eydx_lo_reg);
        lx_dy_next = (PW'(lxdy_hi_reg) <<< LW) + PW'(lxdy_lo_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv3) v3_reg <= in_valid;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            exdy_lo_reg <= PLW'(enter_x) * PLW'(dy_lo);
            exdy_hi_reg <= PHW'(enter_x) * PHW'(dy_hi);
            lydx_lo_reg <= PLW'(leave_y) * PLW'(dx_lo);
            lydx_hi_reg <= PHW'(leave_y) * PHW'(dx_hi);
            eydx_lo_reg <= PLW'(enter_y) * PLW'(dx_lo);
            eydx_hi_reg <= PHW'(enter_y) * PHW'(dx_hi);
            lxdy_lo_reg <= PLW'(leave_x) * PLW'(dy_lo);
            lxdy_hi_reg <= PHW'(leave_x) * PHW'(dy_hi);
            flags3_reg  <= flags3_next;
        end
        if (adv4) begin
            ex_dy_reg  <= ex_dy_next;
            ly_dx_reg  <= ly_dx_next;
            ey_dx_reg  <= ey_dx_next;
            lx_dy_reg  <= lx_dy_next;
            flags4_reg <= flags3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign ex_dy     = ex_dy_reg;
    assign ly_dx     = ly_dx_reg;
    assign ey_dx     = ey_dx_reg;
    assign lx_dy     = lx_dy_reg;
    assign out_flags = flags4_reg;

endmodule

// ===== hdl/segment_box_slab_test.sv =====
// Segment against axis-aligned box test, 2D slab method, inclusive edges.
//
// Input channel (s_valid / s_ready): one beat carries a box (min and max
// corners) and a segment (start and end point), all signed Q15.16. Only the
// low COORD_WIDTH bits of each coordinate are used, sign-extended.
// Result channel (m_valid / m_ready): one beat per input beat, in order;
// m_hit is high when the closed segment touches or crosses the closed box.
//
// Five register stages: differences, orientation and sort, partial
// products, full cross products, final compare into the output register.
// A new beat is taken every cycle while the output is not stalled; the split
// 2x(W+1) by W/2 multipliers set the stage depth.
// When m_ready is low the output register holds and bubbles ahead of it are
// squeezed out; s_ready drops only once every stage holds an item.
// Reset (aresetn low, synchronous) empties the pipeline; m_valid goes low.
module segment_box_slab_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  s_box_min_x,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  s_box_min_y,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  s_box_max_x,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  s_box_max_y,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  s_start_x,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  s_start_y,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  s_end_x,
    input  logic signed [sbst_pkg::FIELD_W-1:0]  s_end_y,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit
);
    import sbst_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * COORD_WIDTH + 1;

    logic               prep_valid, prep_ready;
    logic signed [CW:0] enter_x, leave_x, enter_y, leave_y;
    logic [CW-1:0]      dmag_x, dmag_y;
    sbst_flags_t        prep_flags;

    logic                 dec_valid, dec_ready;
    logic signed [PW-1:0] ex_dy, ly_dx, ey_dx, lx_dy;
    sbst_flags_t          dec_flags;

    logic m_valid_reg, m_hit_reg, m_hit_next;
    logic adv5;

    sbst_prep #(.COORD_WIDTH(COORD_WIDTH)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .box_min_x (s_box_min_x),
        .box_min_y (s_box_min_y),
        .box_max_x (s_box_max_x),
        .box_max_y (s_box_max_y),
        .start_x   (s_start_x),
        .start_y   (s_start_y),
        .end_x     (s_end_x),
        .end_y     (s_end_y),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .enter_x   (enter_x),
        .leave_x   (leave_x),
        .enter_y   (enter_y),
        .leave_y   (leave_y),
        .dmag_x    (dmag_x),
        .dmag_y    (dmag_y),
        .flags     (prep_flags)
    );

    sbst_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .enter_x   (enter_x),
        .leave_x   (leave_x),
        .enter_y   (enter_y),
        .leave_y   (leave_y),
        .dmag_x    (dmag_x),
        .dmag_y    (dmag_y),
        .in_flags  (prep_flags),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .ex_dy     (ex_dy),
        .ly_dx     (ly_dx),
        .ey_dx     (ey_dx),
        .lx_dy     (lx_dy),
        .out_flags (dec_flags)
    );

    assign adv5      = !m_valid_reg || m_ready;
    assign dec_ready = adv5;

    // Entry on one axis must not pass exit on the other; a stationary axis
    // has already been settled by its slab check
    always_comb begin
        m_hit_next = dec_flags.start_in
            || (!dec_flags.miss
                && (dec_flags.dx_zero || dec_flags.dy_zero
                    || ((ex_dy <= ly_dx) && (ey_dx <= lx_dy))));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv5) begin
            m_valid_reg <= dec_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv5) begin
            m_hit_reg <= m_hit_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;

    a_inside_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv5 && dec_valid && dec_flags.start_in) |=> (m_valid && m_hit))
        else $error("start inside box did not give a hit");

    a_miss_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv5 && dec_valid && dec_flags.miss && !dec_flags.start_in) |=> !m_hit)
        else $error("known miss reported as hit");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output free");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
